// ===== hdl/sltl_pkg.sv =====
// ----------------------------------------------------------------------------
// sltl_pkg
// Shared types and constants for the sleep timer list block.
// ----------------------------------------------------------------------------
package sltl_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam int ID_W   = 16;
   localparam int MS_W   = 32;
   localparam int TPM_W  = 10;
   localparam int TICK_W = 32;
   localparam int PROD_W = MS_W + TPM_W;
   localparam int KIND_W = 2;

   localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(1);

   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ZERO     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_WOKEN    = 2'd3;

   localparam logic ACTION_SLEEP = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_APPEND,
      ST_WALK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load_sleep;   // latch sleep request payload
      logic load_walk;    // clear walk pointers
      logic mul;          // register the tick product
      logic append;       // store entry or reject, emit result
      logic walk;         // one step of the countdown walk
      logic flush;        // emit held wake, commit count
   } cmd_type;

   typedef struct packed {
      logic walk_done;
   } status_type;

endpackage

// ===== hdl/sleep_timer_list.sv =====
// ----------------------------------------------------------------------------
// sleep_timer_list
// Ordered table of sleeping thread ids with tick countdowns.
// ----------------------------------------------------------------------------
// Sleep request: busy through the MUL and APPEND states, then one registered
//   result; a new request is taken only once the block is idle again.
// Tick: walk of one entry per cycle through the entry memory (one read port),
//   busy through the WALK and FLUSH states; wakes come out at most one per cycle.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
// Synchronous reset empties the table and sets ticks_per_ms to 1.
// ----------------------------------------------------------------------------
module sleep_timer_list #(
   parameter int SLOTS = sltl_pkg::SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_action,
   input  logic [sltl_pkg::ID_W-1:0]    req_thread_id,
   input  logic [sltl_pkg::MS_W-1:0]    req_sleep_ms,
   input  logic                         csr_wr_en,
   input  logic [sltl_pkg::TPM_W-1:0]   csr_wr_data,
   output logic                         rsp_valid,
   output logic [sltl_pkg::KIND_W-1:0]  rsp_result_kind,
   output logic [sltl_pkg::ID_W-1:0]    rsp_woken_id,
   output logic                         rsp_last
);

   sltl_pkg::cmd_type    cmd;
   sltl_pkg::status_type status;

   sltl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   sltl_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_thread_id   (req_thread_id),
      .req_sleep_ms    (req_sleep_ms),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .rsp_woken_id    (rsp_woken_id),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== hdl/sltl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sltl_ctrl
// Sequencer for the sleep timer list: sleep path and tick walk.
// ----------------------------------------------------------------------------
module sltl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_action,
   input  sltl_pkg::status_type  status,
   output sltl_pkg::cmd_type     cmd,
   output logic                  busy
);

   sltl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sltl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         sltl_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_action == sltl_pkg::ACTION_SLEEP) begin
                  cmd.load_sleep = 1'b1;
                  state_in       = sltl_pkg::ST_MUL;
               end else begin
                  cmd.load_walk = 1'b1;
                  state_in      = sltl_pkg::ST_WALK;
               end
            end
         end
         sltl_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = sltl_pkg::ST_APPEND;
         end
         sltl_pkg::ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = sltl_pkg::ST_IDLE;
         end
         sltl_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               state_in = sltl_pkg::ST_FLUSH;
            end
         end
         sltl_pkg::ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = sltl_pkg::ST_IDLE;
         end
         default: begin
            state_in = sltl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/sltl_dp.sv =====
// ----------------------------------------------------------------------------
// sltl_dp
// Datapath: entry memory, occupancy count, tick product, walk pointers and
// the registered result port.
// ----------------------------------------------------------------------------
module sltl_dp #(
   parameter int SLOTS = sltl_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sltl_pkg::cmd_type               cmd,
   output sltl_pkg::status_type            status,
   input  logic [sltl_pkg::ID_W-1:0]       req_thread_id,
   input  logic [sltl_pkg::MS_W-1:0]       req_sleep_ms,
   input  logic                            csr_wr_en,
   input  logic [sltl_pkg::TPM_W-1:0]      csr_wr_data,
   output logic                            rsp_valid,
   output logic [sltl_pkg::KIND_W-1:0]     rsp_result_kind,
   output logic [sltl_pkg::ID_W-1:0]       rsp_woken_id,
   output logic                            rsp_last
);

   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ENT_W = sltl_pkg::ID_W + sltl_pkg::TICK_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);

   // entry memory: {thread, ticks left}
   logic [ENT_W-1:0] mem [SLOTS];

   logic [sltl_pkg::TPM_W-1:0]  tpm_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [sltl_pkg::ID_W-1:0]   tid_ff;
   logic [sltl_pkg::MS_W-1:0]   ms_ff;
   logic [sltl_pkg::PROD_W-1:0] prod_ff;
   logic [CNT_W-1:0]            rd_idx_ff;
   logic [CNT_W-1:0]            keep_ff;
   logic                        rd_valid_ff;
   logic [ENT_W-1:0]            rd_data_ff;
   logic                        pend_valid_ff;
   logic [sltl_pkg::ID_W-1:0]   pend_id_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [sltl_pkg::KIND_W-1:0] rsp_kind_ff;
   logic [sltl_pkg::ID_W-1:0]   rsp_id_ff;
   logic                        rsp_last_ff;

   logic [sltl_pkg::TICK_W-1:0] ticks_sat;
   logic                        ticks_zero;
   logic                        full;
   logic [sltl_pkg::ID_W-1:0]   rd_thread;
   logic [sltl_pkg::TICK_W-1:0] rd_left;
   logic                        rd_wakes;
   logic                        issue;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [ENT_W-1:0]            wr_data;

   assign ticks_sat  = (|prod_ff[sltl_pkg::PROD_W-1:sltl_pkg::TICK_W]) ? '1
                       : prod_ff[sltl_pkg::TICK_W-1:0];
   assign ticks_zero = (prod_ff == '0);
   assign full       = (count_ff >= CNT_FULL);

   assign rd_thread = rd_data_ff[ENT_W-1:sltl_pkg::TICK_W];
   assign rd_left   = rd_data_ff[sltl_pkg::TICK_W-1:0] - sltl_pkg::TICK_W'(1);
   assign rd_wakes  = (rd_left == '0);
   assign issue     = cmd.walk && (rd_idx_ff < count_ff);

   assign status.walk_done = (rd_idx_ff >= count_ff) && !rd_valid_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = {tid_ff, ticks_sat};
      if (cmd.append && !ticks_zero && !full) begin
         wr_en = 1'b1;
      end else if (cmd.walk && rd_valid_ff && !rd_wakes) begin
         wr_en   = 1'b1;
         wr_addr = keep_ff[IDX_W-1:0];
         wr_data = {rd_thread, rd_left};
      end
   end

   // a new wake shows the held one is not the last
   always_comb begin
      rsp_valid_in = 1'b0;
      if (cmd.append) begin
         rsp_valid_in = 1'b1;
      end else if (cmd.walk && rd_valid_ff && rd_wakes) begin
         rsp_valid_in = pend_valid_ff;
      end else if (cmd.flush) begin
         rsp_valid_in = pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_sleep) begin
         tid_ff <= req_thread_id;
         ms_ff  <= req_sleep_ms;
      end
      if (cmd.mul) begin
         prod_ff <= sltl_pkg::PROD_W'(ms_ff) * sltl_pkg::PROD_W'(tpm_ff);
      end
      if (cmd.walk && rd_valid_ff && rd_wakes) begin
         pend_id_ff <= rd_thread;
      end
      if (cmd.append) begin
         rsp_kind_ff <= ticks_zero ? sltl_pkg::KIND_ZERO
                        : (full ? sltl_pkg::KIND_FULL : sltl_pkg::KIND_ACCEPTED);
         rsp_id_ff   <= tid_ff;
         rsp_last_ff <= 1'b1;
      end else if (cmd.walk || cmd.flush) begin
         rsp_kind_ff <= sltl_pkg::KIND_WOKEN;
         rsp_id_ff   <= pend_id_ff;
         rsp_last_ff <= cmd.flush;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff        <= sltl_pkg::TPM_RESET;
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         keep_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tpm_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load_walk) begin
            rd_idx_ff     <= '0;
            keep_ff       <= '0;
            rd_valid_ff   <= 1'b0;
            pend_valid_ff <= 1'b0;
         end
         if (cmd.append) begin
            if (!ticks_zero && !full) begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end
         if (cmd.walk) begin
            rd_valid_ff <= issue;
            if (issue) begin
               rd_idx_ff <= rd_idx_ff + CNT_W'(1);
            end
            if (rd_valid_ff) begin
               if (rd_wakes) begin
                  pend_valid_ff <= 1'b1;
               end else begin
                  keep_ff <= keep_ff + CNT_W'(1);
               end
            end
         end
         if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
            count_ff      <= keep_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_woken_id    = rsp_id_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== hdl/sltl_checker.sv =====
// ----------------------------------------------------------------------------
// sltl_checker
// Port-level checks for sleep_timer_list, bound to the top level.
// ----------------------------------------------------------------------------
module sltl_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_action,
   input logic                         rsp_valid,
   input logic [sltl_pkg::KIND_W-1:0]  rsp_result_kind,
   input logic                         rsp_last
);

   logic sleep_xfer;
   logic any_xfer;

   assign any_xfer   = start && !busy;
   assign sleep_xfer = any_xfer && (req_action == sltl_pkg::ACTION_SLEEP);

   // every transfer holds the block busy for the next cycle
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      any_xfer |=> busy)
      else $error("busy low after transfer");

   // a sleep request is answered by a final result that is not a wake
   a_sleep_rsp: assert property (@(posedge clock) disable iff (reset)
      sleep_xfer |-> ##3 (rsp_valid && rsp_last
                          && rsp_result_kind != sltl_pkg::KIND_WOKEN))
      else $error("sleep request result missing or malformed");

   // only wakes may be non-final
   a_nonwake_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != sltl_pkg::KIND_WOKEN) |-> rsp_last)
      else $error("sleep result without last");

   // a result never appears unless the block was busy in the previous cycle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result while idle");

endmodule

bind sleep_timer_list sltl_checker u_sltl_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_action      (req_action),
   .rsp_valid       (rsp_valid),
   .rsp_result_kind (rsp_result_kind),
   .rsp_last        (rsp_last)
);
